// File: design/gmnc_pkg.sv
// gmnc_pkg: shared types, codes and constant tables of the grid map neighbor cost unit
// depends on nothing; imported by every module of the block
`default_nettype none

package gmnc_pkg;

  // fixed field widths
  localparam int ID_W    = 12;   // cell id
  localparam int COORD_W = 7;    // column / row coordinate and grid size registers
  localparam int XY_W    = 6;    // coordinates carried by a write request
  localparam int CELL_W  = 14;   // columns * rows

  localparam logic [COORD_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_EXPAND = 2'd2
  } gmnc_kind_e;

  typedef enum logic {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } gmnc_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_WB,
    ST_Q_DIVF,
    ST_Q_DIVT,
    ST_Q_RD,
    ST_Q_EVAL,
    ST_E_DIV,
    ST_E_RD0,
    ST_E_RD1,
    ST_E_RD2,
    ST_E_RD3,
    ST_E_EMIT
  } gmnc_state_e;

  // neighbor order: column and row slot (0 = minus one, 1 = same, 2 = plus one)
  localparam logic [1:0] NB_COL [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] NB_ROW [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  // position of the neighbor in the 3x3 window of blocked bits (row * 3 + column)
  localparam logic [3:0] NB_BIT [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8};

endpackage

`default_nettype wire

// File: design/gmnc_div.sv
// gmnc_div: bit-serial restoring divider, cell id by column count
// depends on gmnc_pkg; one quotient bit per cycle
`default_nettype none

module gmnc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gmnc_pkg::ID_W-1:0]    dividend_i,
  input  logic [gmnc_pkg::COORD_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [gmnc_pkg::ID_W-1:0]    quotient_o,
  output logic [gmnc_pkg::COORD_W-1:0] remainder_o
);
  import gmnc_pkg::*;

  localparam int CNT_W = $clog2(ID_W);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ID_W-1:0]      quo_q, quo_d;
  logic [COORD_W-1:0]   rem_q, rem_d;
  logic [COORD_W:0]     trial;
  logic [COORD_W:0]     diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[ID_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(ID_W - 1);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      // remainder stays below the divisor, so it fits the coordinate width
      rem_d = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quo_d = {quo_q[ID_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: design/gmnc_map.sv
// gmnc_map: blocked map, one memory row per grid row, registered read
// depends on gmnc_pkg; clears itself row by row after reset
`default_nettype none

module gmnc_map #(
  parameter  int MAX_COLUMNS = 64,
  parameter  int MAX_ROWS    = 64,
  localparam int RW          = $clog2(MAX_ROWS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [RW-1:0]          rd_row_i,
  output logic [MAX_COLUMNS-1:0] rd_data_o,
  input  logic                   wr_en_i,
  input  logic [RW-1:0]          wr_row_i,
  input  logic [MAX_COLUMNS-1:0] wr_data_i,
  output logic                   clearing_o
);
  import gmnc_pkg::*;

  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd_data_q;
  logic                   clr_q, clr_d;
  logic [RW-1:0]          clr_row_q, clr_row_d;
  logic                   we;
  logic [RW-1:0]          wrow;
  logic [MAX_COLUMNS-1:0] wdata;

  // clearing pass owns the write port until the last row is zeroed
  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      clr_row_d = clr_row_q + 1'b1;
      if (clr_row_q == RW'(MAX_ROWS - 1)) begin
        clr_d = 1'b0;
      end
    end
    we    = clr_q | wr_en_i;
    wrow  = clr_q ? clr_row_q : wr_row_i;
    wdata = clr_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wrow] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

// File: design/grid_map_neighbor_cost_unit.sv
// grid_map_neighbor_cost_unit: top level, request sequencer and result registers
// depends on gmnc_pkg, gmnc_div and gmnc_map
`default_nettype none

// Blocked-cell map for 8-connected path search without corner cutting. A request is taken
// when start is high and busy is low; busy drops in the cycle that carries the request's
// last result. Results appear on result_valid_o for one cycle each and cannot be held off,
// so the receiver must take them as they come. A write reads the row, then writes it back
// and gives its result; a write outside the grid, a same-cell query and a query with an id
// outside the grid answer straight from the idle state; any other query runs the bit-serial
// divider twice (a pass is a load, then one quotient bit a cycle) and answers after the
// second pass when the cells are not neighbors, else after reading the target row and then
// the source row; an expansion runs one divider pass and three row reads, then gives eight
// results, one a cycle; an expansion of a source outside the grid skips both and gives its
// eight results directly. A request of the unused kind gives no result. After reset the
// map clears itself row by row, with busy high; configuration writes are taken during
// that time.
module grid_map_neighbor_cost_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [gmnc_pkg::XY_W-1:0]    cell_x_i,
  input  logic [gmnc_pkg::XY_W-1:0]    cell_y_i,
  input  logic                         block_flag_i,
  input  logic [gmnc_pkg::ID_W-1:0]    from_id_i,
  input  logic [gmnc_pkg::ID_W-1:0]    to_id_i,
  // configuration
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [gmnc_pkg::COORD_W-1:0] cfg_data_i,
  // results
  output logic                         result_valid_o,
  output logic                         reachable_o,
  output logic                         step_cost_o,
  output logic [gmnc_pkg::ID_W-1:0]    neighbor_id_o,
  output logic                         neighbor_valid_o,
  output logic                         last_o
);
  import gmnc_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  // grid size registers cannot exceed their own width
  localparam int COL_CAP = (MAX_COLUMNS < 127) ? MAX_COLUMNS : 127;
  localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;

  // configuration registers and effective grid size
  logic [COORD_W-1:0] cfg_cols_q, cfg_rows_q;
  logic [COORD_W-1:0] cols, rows;
  logic [CELL_W-1:0]  cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= CFG_RESET;
      cfg_rows_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS: cfg_cols_q <= cfg_data_i;
        CFG_ROWS:    cfg_rows_q <= cfg_data_i;
        default:     cfg_rows_q <= cfg_rows_q;
      endcase
    end
  end

  // zero counts as one, anything above the map size is clamped to it
  always_comb begin
    if (cfg_cols_q == '0) begin
      cols = 7'd1;
    end else if (cfg_cols_q > COORD_W'(COL_CAP)) begin
      cols = COORD_W'(COL_CAP);
    end else begin
      cols = cfg_cols_q;
    end
    if (cfg_rows_q == '0) begin
      rows = 7'd1;
    end else if (cfg_rows_q > COORD_W'(ROW_CAP)) begin
      rows = COORD_W'(ROW_CAP);
    end else begin
      rows = cfg_rows_q;
    end
  end

  assign cells = {7'd0, cols} * {7'd0, rows};

  // sequencer state and per-request registers
  gmnc_state_e        state_q, state_d;
  logic [XY_W-1:0]    wx_q, wx_d, wy_q, wy_d;
  logic               flag_q, flag_d;
  logic [ID_W-1:0]    from_q, from_d, to_q, to_d;
  logic [COORD_W-1:0] fx_q, fx_d, fy_q, fy_d, tx_q, tx_d;
  logic               diag_q, diag_d;
  logic               tgt_blk_q, tgt_blk_d;
  logic               corner_a_q, corner_a_d;
  logic               src_ok_q, src_ok_d;
  logic [8:0]         blk_q, blk_d;
  logic [2:0]         k_q, k_d;

  // shared divider
  logic               div_start;
  logic [ID_W-1:0]    div_dividend;
  logic               div_done;
  logic [ID_W-1:0]    div_quo;
  logic [COORD_W-1:0] div_rem;

  gmnc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (cols),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // blocked map
  logic                   map_rd_en;
  logic [RW-1:0]          map_rd_row;
  logic [MAX_COLUMNS-1:0] map_rd_data;
  logic                   map_wr_en;
  logic [MAX_COLUMNS-1:0] row_mod;
  logic                   map_clearing;

  gmnc_map #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (map_rd_en),
    .rd_row_i   (map_rd_row),
    .rd_data_o  (map_rd_data),
    .wr_en_i    (map_wr_en),
    .wr_row_i   (RW'(wy_q)),
    .wr_data_i  (row_mod),
    .clearing_o (map_clearing)
  );

  // read-modify-write of the row holding the written cell
  always_comb begin
    row_mod            = map_rd_data;
    row_mod[CW'(wx_q)] = flag_q;
  end

  logic accept;
  assign busy   = (state_q != ST_IDLE) || map_clearing;
  assign accept = start && !busy;

  logic write_in_grid;
  logic ids_in_grid;
  logic src_in_grid;
  assign write_in_grid = ({1'b0, cell_x_i} < cols) && ({1'b0, cell_y_i} < rows);
  assign src_in_grid   = {2'b00, from_id_i} < cells;
  assign ids_in_grid   = src_in_grid && ({2'b00, to_id_i} < cells);

  // query distance check against the target coordinates coming out of the divider
  logic [COORD_W-1:0] q_ty, ax, ay;
  logic               q_adj, q_diag;
  assign q_ty   = COORD_W'(div_quo);
  assign ax     = (div_rem > fx_q) ? (div_rem - fx_q) : (fx_q - div_rem);
  assign ay     = (q_ty > fy_q) ? (q_ty - fy_q) : (fy_q - q_ty);
  assign q_adj  = (ax <= 7'd1) && (ay <= 7'd1);
  assign q_diag = (ax == 7'd1) && (ay == 7'd1);

  // 3x3 window around the source for an expansion
  logic          x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
  logic [CW-1:0] col_l, col_m, col_r;
  logic [RW-1:0] row_up, row_dn;
  logic [2:0]    win_bits;
  logic [2:0]    x_ok_vec, y_ok_vec;

  assign x_lo_ok  = fx_q != '0;
  assign x_hi_ok  = ({1'b0, fx_q} + 8'd1) < {1'b0, cols};
  assign y_lo_ok  = fy_q != '0;
  assign y_hi_ok  = ({1'b0, fy_q} + 8'd1) < {1'b0, rows};
  assign col_l    = x_lo_ok ? CW'(fx_q - 7'd1) : CW'(fx_q);
  assign col_m    = CW'(fx_q);
  assign col_r    = x_hi_ok ? CW'(fx_q + 7'd1) : CW'(fx_q);
  assign row_up   = y_lo_ok ? RW'(fy_q - 7'd1) : RW'(fy_q);
  assign row_dn   = y_hi_ok ? RW'(fy_q + 7'd1) : RW'(fy_q);
  assign win_bits = {map_rd_data[col_r], map_rd_data[col_m], map_rd_data[col_l]};
  assign x_ok_vec = {x_hi_ok, 1'b1, x_lo_ok};
  assign y_ok_vec = {y_hi_ok, 1'b1, y_lo_ok};

  // current neighbor of the expansion
  logic [1:0]      nb_col, nb_row;
  logic            nb_ok;
  logic [ID_W-1:0] row_off, col_off, nb_id;

  assign nb_col = NB_COL[k_q];
  assign nb_row = NB_ROW[k_q];
  assign nb_ok  = src_ok_q && x_ok_vec[nb_col] && y_ok_vec[nb_row] && !blk_q[NB_BIT[k_q]];

  always_comb begin
    unique case (nb_row)
      2'd0:    row_off = 12'd0 - {5'd0, cols};
      2'd2:    row_off = {5'd0, cols};
      default: row_off = '0;
    endcase
    unique case (nb_col)
      2'd0:    col_off = 12'hFFF;
      2'd2:    col_off = 12'd1;
      default: col_off = '0;
    endcase
  end

  // wraps to 12 bits; exact whenever the neighbor is inside the grid
  assign nb_id = from_q + row_off + col_off;

  // result to register this cycle
  logic            emit;
  logic            e_reach, e_cost, e_nvalid, e_last;
  logic [ID_W-1:0] e_nid;

  always_comb begin
    state_d      = state_q;
    wx_d         = wx_q;
    wy_d         = wy_q;
    flag_d       = flag_q;
    from_d       = from_q;
    to_d         = to_q;
    fx_d         = fx_q;
    fy_d         = fy_q;
    tx_d         = tx_q;
    diag_d       = diag_q;
    tgt_blk_d    = tgt_blk_q;
    corner_a_d   = corner_a_q;
    src_ok_d     = src_ok_q;
    blk_d        = blk_q;
    k_d          = k_q;
    div_start    = 1'b0;
    div_dividend = from_q;
    map_rd_en    = 1'b0;
    map_rd_row   = RW'(fy_q);
    map_wr_en    = 1'b0;
    emit         = 1'b0;
    e_reach      = 1'b0;
    e_cost       = 1'b0;
    e_nid        = '0;
    e_nvalid     = 1'b0;
    e_last       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wx_d   = cell_x_i;
          wy_d   = cell_y_i;
          flag_d = block_flag_i;
          from_d = from_id_i;
          to_d   = to_id_i;
          unique case (kind_i)
            KIND_WRITE: begin
              if (write_in_grid) begin
                map_rd_en  = 1'b1;
                map_rd_row = RW'(cell_y_i);
                state_d    = ST_WR_WB;
              end else begin
                // outside the grid: map untouched, plain acknowledge
                emit   = 1'b1;
                e_last = 1'b1;
              end
            end
            KIND_QUERY: begin
              if (from_id_i == to_id_i) begin
                emit    = 1'b1;
                e_reach = 1'b1;
                e_last  = 1'b1;
              end else if (!ids_in_grid) begin
                emit   = 1'b1;
                e_last = 1'b1;
              end else begin
                div_start    = 1'b1;
                div_dividend = from_id_i;
                state_d      = ST_Q_DIVF;
              end
            end
            KIND_EXPAND: begin
              src_ok_d = src_in_grid;
              k_d      = '0;
              if (src_in_grid) begin
                div_start    = 1'b1;
                div_dividend = from_id_i;
                state_d      = ST_E_DIV;
              end else begin
                state_d = ST_E_EMIT;
              end
            end
            default: begin
              // unused kind: dropped without a result
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_WR_WB: begin
        map_wr_en = 1'b1;
        emit      = 1'b1;
        e_last    = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_Q_DIVF: begin
        if (div_done) begin
          fx_d         = div_rem;
          fy_d         = COORD_W'(div_quo);
          div_start    = 1'b1;
          div_dividend = to_q;
          state_d      = ST_Q_DIVT;
        end
      end

      ST_Q_DIVT: begin
        if (div_done) begin
          tx_d   = div_rem;
          diag_d = q_diag;
          if (q_adj) begin
            // target row first: target bit and the corner in the source column
            map_rd_en  = 1'b1;
            map_rd_row = RW'(q_ty);
            state_d    = ST_Q_RD;
          end else begin
            emit    = 1'b1;
            e_last  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_Q_RD: begin
        tgt_blk_d  = map_rd_data[CW'(tx_q)];
        corner_a_d = map_rd_data[CW'(fx_q)];
        map_rd_en  = 1'b1;
        map_rd_row = RW'(fy_q);
        state_d    = ST_Q_EVAL;
      end

      ST_Q_EVAL: begin
        // source row now holds the other corner
        emit    = 1'b1;
        e_reach = !tgt_blk_q && (!diag_q || (!corner_a_q && !map_rd_data[CW'(tx_q)]));
        e_cost  = e_reach;
        e_last  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_E_DIV: begin
        if (div_done) begin
          fx_d    = div_rem;
          fy_d    = COORD_W'(div_quo);
          state_d = ST_E_RD0;
        end
      end

      ST_E_RD0: begin
        map_rd_en  = 1'b1;
        map_rd_row = row_up;
        state_d    = ST_E_RD1;
      end

      ST_E_RD1: begin
        blk_d[2:0] = win_bits;
        map_rd_en  = 1'b1;
        map_rd_row = RW'(fy_q);
        state_d    = ST_E_RD2;
      end

      ST_E_RD2: begin
        blk_d[5:3] = win_bits;
        map_rd_en  = 1'b1;
        map_rd_row = row_dn;
        state_d    = ST_E_RD3;
      end

      ST_E_RD3: begin
        blk_d[8:6] = win_bits;
        k_d        = '0;
        state_d    = ST_E_EMIT;
      end

      ST_E_EMIT: begin
        emit     = 1'b1;
        e_nvalid = nb_ok;
        e_nid    = nb_ok ? nb_id : '0;
        e_last   = k_q == 3'd7;
        k_d      = k_q + 1'b1;
        if (k_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q       <= wx_d;
    wy_q       <= wy_d;
    flag_q     <= flag_d;
    from_q     <= from_d;
    to_q       <= to_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    tx_q       <= tx_d;
    diag_q     <= diag_d;
    tgt_blk_q  <= tgt_blk_d;
    corner_a_q <= corner_a_d;
    src_ok_q   <= src_ok_d;
    blk_q      <= blk_d;
  end

  // result registers, each result shown for a single cycle
  logic            res_valid_q;
  logic            res_reach_q, res_cost_q, res_nvalid_q, res_last_q;
  logic [ID_W-1:0] res_nid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    res_reach_q  <= e_reach;
    res_cost_q   <= e_cost;
    res_nid_q    <= e_nid;
    res_nvalid_q <= e_nvalid;
    res_last_q   <= e_last;
  end

  assign result_valid_o   = res_valid_q;
  assign reachable_o      = res_reach_q;
  assign step_cost_o      = res_cost_q;
  assign neighbor_id_o    = res_nid_q;
  assign neighbor_valid_o = res_nvalid_q;
  assign last_o           = res_last_q;

`ifndef SYNTHESIS
  // no request is taken while the map is still being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) map_clearing |-> busy)
    else $error("map clearing without busy");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_Q_DIVF || state_q == ST_Q_DIVT || state_q == ST_E_DIV))
    else $error("divider finished outside a divide state");

  // eighth neighbor closes the expansion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_E_EMIT && k_q == 3'd7) |=> (result_valid_o && last_o && !busy))
    else $error("expansion did not close on the eighth neighbor");

  // a reachable query result never carries a neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && reachable_o) |-> !neighbor_valid_o)
    else $error("reachable and neighbor valid together");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
// testbench: self-checking bench for the grid map neighbor cost unit (writes, cost queries,
// neighbor expansions) against a predictor of the blocked map, under several grid sizes
// depends on gmnc_pkg and grid_map_neighbor_cost_unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gmnc_pkg::*;

  localparam int GRID_MAX        = 64;      // map dimension of the default build
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 24;
  localparam int PHASES          = 8;
  localparam int MAX_REPORTS     = 10;
  localparam int HOT_SPAN        = 6;       // corner window where most traffic lands
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [XY_W-1:0] cell_x;
    logic [XY_W-1:0] cell_y;
    logic            block_flag;
    logic [ID_W-1:0] from_id;
    logic [ID_W-1:0] to_id;
  } cost_request_t;

  typedef struct packed {
    logic            reachable;
    logic            step_cost;
    logic [ID_W-1:0] neighbor_id;
    logic            neighbor_valid;
    logic            last;
  } cost_result_t;

  // one row of the directed part: a register write or a request, with an optional typed answer
  typedef struct packed {
    logic                is_cfg;
    gmnc_cfg_e           cfg_sel;
    logic [COORD_W-1:0]  cfg_val;
    cost_request_t       req;
    logic                typed;
    logic                t_reach;
    logic                t_cost;
  } stim_row_t;

  logic               clk;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic [XY_W-1:0]    cell_x_i;
  logic [XY_W-1:0]    cell_y_i;
  logic               block_flag_i;
  logic [ID_W-1:0]    from_id_i;
  logic [ID_W-1:0]    to_id_i;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [COORD_W-1:0] cfg_data_i;
  logic               result_valid_o;
  logic               reachable_o;
  logic               step_cost_o;
  logic [ID_W-1:0]    neighbor_id_o;
  logic               neighbor_valid_o;
  logic               last_o;

  // predictor state: blocked bits by (row, column) and the two size registers
  bit                 blocked_map [GRID_MAX][GRID_MAX];
  logic [COORD_W-1:0] columns_reg;
  logic [COORD_W-1:0] rows_reg;

  cost_result_t pending_results [$];
  stim_row_t    stim_rows [$];
  int           mismatches;
  int           cycle_count;

  grid_map_neighbor_cost_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .block_flag_i     (block_flag_i),
    .from_id_i        (from_id_i),
    .to_id_i          (to_id_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .reachable_o      (reachable_o),
    .step_cost_o      (step_cost_o),
    .neighbor_id_o    (neighbor_id_o),
    .neighbor_valid_o (neighbor_valid_o),
    .last_o           (last_o)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size register as the block sees it: zero means one, above the map means the map
  function automatic int clamp_size(input logic [COORD_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // cells outside the grid read as free
  function automatic bit cell_blocked(input int x, input int y, input int cols, input int rows);
    if (x < 0 || y < 0 || x >= cols || y >= rows) return 1'b0;
    return blocked_map[y][x];
  endfunction

  // queue one expected result behind the older ones
  function automatic void expect_result(input cost_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // work out the results of one accepted request and queue them, oldest first
  task automatic predict_request(input cost_request_t r, input logic typed,
                                 input cost_result_t typed_res);
    int cols, rows, cells;
    int fid, tid, fx, fy, tx, ty, ax, ay, nx, ny;
    cost_result_t res;
    cols  = clamp_size(columns_reg);
    rows  = clamp_size(rows_reg);
    cells = cols * rows;
    fid   = int'(r.from_id);
    tid   = int'(r.to_id);
    fx    = fid % cols;
    fy    = fid / cols;
    res   = '0;
    case (r.kind)
      KIND_WRITE: begin
        // a write outside the grid leaves the map alone but still answers
        if (int'(r.cell_x) < cols && int'(r.cell_y) < rows)
          blocked_map[r.cell_y][r.cell_x] = r.block_flag;
        res.last = 1'b1;
        expect_result(typed ? typed_res : res);
      end
      KIND_QUERY: begin
        if (fid == tid) begin
          // same cell: always reachable at no cost
          res.reachable = 1'b1;
        end else if (fid < cells && tid < cells) begin
          tx = tid % cols;
          ty = tid / cols;
          ax = (tx > fx) ? tx - fx : fx - tx;
          ay = (ty > fy) ? ty - fy : fy - ty;
          if (!cell_blocked(tx, ty, cols, rows) && ax <= 1 && ay <= 1) begin
            // diagonal steps need both corner cells free
            if (ax + ay == 1 ||
                (!cell_blocked(fx, ty, cols, rows) && !cell_blocked(tx, fy, cols, rows))) begin
              res.reachable = 1'b1;
              res.step_cost = 1'b1;
            end
          end
        end
        res.last = 1'b1;
        expect_result(typed ? typed_res : res);
      end
      KIND_EXPAND: begin
        for (int k = 0; k < 8; k++) begin
          res = '0;
          nx  = fx + int'(NB_COL[k]) - 1;
          ny  = fy + int'(NB_ROW[k]) - 1;
          if (fid < cells && nx >= 0 && ny >= 0 && nx < cols && ny < rows &&
              !cell_blocked(nx, ny, cols, rows)) begin
            res.neighbor_valid = 1'b1;
            res.neighbor_id    = ID_W'(ny * cols + nx);
          end
          res.last = (k == 7);
          expect_result(res);
        end
      end
      default: ;  // unused kind: no result
    endcase
  endtask

  // present one request from the falling edge and hold it until the block takes it
  task automatic issue_request(input cost_request_t r, input logic typed,
                               input cost_result_t typed_res);
    @(negedge clk);
    start        = 1'b1;
    kind_i       = r.kind;
    cell_x_i     = r.cell_x;
    cell_y_i     = r.cell_y;
    block_flag_i = r.block_flag;
    from_id_i    = r.from_id;
    to_id_i      = r.to_id;
    do @(posedge clk); while (busy);
    predict_request(r, typed, typed_res);
  endtask

  // sender gap with start low, its length set by n
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop sending, let every queued result come out, then cover requests with no result
  task automatic wait_drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input gmnc_cfg_e sel, input logic [COORD_W-1:0] val);
    @(negedge clk);
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    @(negedge clk);
    cfg_we_i = 1'b0;
    if (sel == CFG_COLUMNS) columns_reg = val;
    else rows_reg = val;
  endtask

  task automatic table_request(input logic [1:0] kind, input int x, input int y,
                               input logic flag, input int from, input int to,
                               input logic typed, input logic reach, input logic cost);
    stim_row_t row;
    row                = '0;
    row.req.kind       = kind;
    row.req.cell_x     = XY_W'(x);
    row.req.cell_y     = XY_W'(y);
    row.req.block_flag = flag;
    row.req.from_id    = ID_W'(from);
    row.req.to_id      = ID_W'(to);
    row.typed          = typed;
    row.t_reach        = reach;
    row.t_cost         = cost;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic table_config(input gmnc_cfg_e sel, input int val);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_sel = sel;
    row.cfg_val = COORD_W'(val);
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // random request: mostly well-formed traffic near the grid corner, some noise
  task automatic random_request(output cost_request_t r);
    int cols, rows, px, py, fid, dx, dy, sel;
    cols = clamp_size(columns_reg);
    rows = clamp_size(rows_reg);
    // start from noise in every field, then shape the fields that matter
    r.kind       = KIND_UNUSED;
    r.cell_x     = XY_W'($urandom);
    r.cell_y     = XY_W'($urandom);
    r.block_flag = 1'($urandom);
    r.from_id    = ID_W'($urandom);
    r.to_id      = ID_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      px = int'($urandom_range(0, ((cols < HOT_SPAN) ? cols : HOT_SPAN) - 1));
      py = int'($urandom_range(0, ((rows < HOT_SPAN) ? rows : HOT_SPAN) - 1));
    end else begin
      px = int'($urandom_range(0, cols - 1));
      py = int'($urandom_range(0, rows - 1));
    end
    fid = py * cols + px;
    sel = int'($urandom_range(0, 99));
    if (sel < 25) begin
      r.kind = KIND_WRITE;
      if ($urandom_range(0, 9) < 8) begin
        r.cell_x = XY_W'(px);
        r.cell_y = XY_W'(py);
      end
    end else if (sel < 65) begin
      r.kind = KIND_QUERY;
      case ($urandom_range(0, 9))
        0: begin
          r.from_id = ID_W'(fid);
          r.to_id   = ID_W'(fid);
        end
        1: r.from_id = ID_W'(fid);
        2: ;  // both ids random
        default: begin
          // one step in a random direction, possibly off the grid
          dx        = int'($urandom_range(0, 2)) - 1;
          dy        = int'($urandom_range(0, 2)) - 1;
          r.from_id = ID_W'(fid);
          r.to_id   = ID_W'((py + dy) * cols + px + dx);
        end
      endcase
    end else if (sel < 95) begin
      r.kind = KIND_EXPAND;
      if ($urandom_range(0, 7) != 0) r.from_id = ID_W'(fid);
    end
  endtask

  // result checker: every strobe must match the oldest expectation field by field
  always @(posedge clk) begin : result_check
    cost_result_t got;
    cost_result_t want;
    if (rst_ni && result_valid_o) begin
      got = {reachable_o, step_cost_o, neighbor_id_o, neighbor_valid_o, last_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request pending: reach %b cost %b id %0d valid %b last %b",
                   $realtime, got.reachable, got.step_cost, got.neighbor_id,
                   got.neighbor_valid, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.reachable !== want.reachable || got.step_cost !== want.step_cost ||
            got.neighbor_id !== want.neighbor_id ||
            got.neighbor_valid !== want.neighbor_valid || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: reach %b/%b cost %b/%b id %0d/%0d valid %b/%b last %b/%b",
                     $realtime, got.reachable, want.reachable, got.step_cost, want.step_cost,
                     got.neighbor_id, want.neighbor_id, got.neighbor_valid,
                     want.neighbor_valid, got.last, want.last);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cost_request_t req;
    cost_result_t  typed_res;
    stim_row_t     row;
    int            count, burst_left, cols_val, rows_val;
    bit            no_gaps;

    // every input known from time zero, reset held low at the start
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = '0;
    cell_x_i     = '0;
    cell_y_i     = '0;
    block_flag_i = 1'b0;
    from_id_i    = '0;
    to_id_i      = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = 1'b0;
    cfg_data_i   = '0;
    mismatches   = 0;
    columns_reg  = CFG_RESET;
    rows_reg     = CFG_RESET;
    foreach (blocked_map[r, c]) blocked_map[r][c] = 1'b0;
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;

    // directed part at the reset size of 64 x 64, all cells free
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 0, 1'b1, 1'b1, 1'b0);          // same cell
    table_request(KIND_QUERY, 0, 0, 1'b0, 4095, 4095, 1'b1, 1'b1, 1'b0);    // same cell, top id
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 1, 1'b1, 1'b1, 1'b1);          // straight step
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 4095, 1'b1, 1'b0, 1'b0);       // far cell
    table_request(KIND_EXPAND, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0);         // corner
    table_request(KIND_EXPAND, 0, 0, 1'b0, 4095, 0, 1'b0, 1'b0, 1'b0);      // opposite corner
    table_request(KIND_WRITE, 63, 63, 1'b1, 0, 0, 1'b1, 1'b0, 1'b0);
    table_request(KIND_WRITE, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0, 1'b0);
    table_request(KIND_WRITE, 1, 0, 1'b1, 0, 0, 1'b1, 1'b0, 1'b0);
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 65, 1'b1, 1'b0, 1'b0);         // cut corner
    table_request(KIND_QUERY, 0, 0, 1'b0, 65, 1, 1'b1, 1'b0, 1'b0);         // blocked target
    table_request(KIND_QUERY, 0, 0, 1'b0, 65, 64, 1'b1, 1'b1, 1'b1);
    table_request(KIND_QUERY, 0, 0, 1'b0, 1, 2, 1'b0, 1'b0, 1'b0);          // blocked source
    table_request(KIND_EXPAND, 0, 0, 1'b0, 65, 0, 1'b0, 1'b0, 1'b0);
    table_request(KIND_QUERY, 0, 0, 1'b0, 4094, 4095, 1'b1, 1'b0, 1'b0);
    table_request(KIND_UNUSED, 5, 5, 1'b1, 7, 8, 1'b0, 1'b0, 1'b0);         // ignored kind
    // out of range sizes: columns 0 reads as one, rows 127 as the map height
    table_config(CFG_COLUMNS, 0);
    table_config(CFG_ROWS, 127);
    table_request(KIND_WRITE, 1, 0, 1'b0, 0, 0, 1'b1, 1'b0, 1'b0);          // outside grid
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 1, 1'b0, 1'b0, 1'b0);
    table_request(KIND_QUERY, 0, 0, 1'b0, 0, 100, 1'b1, 1'b0, 1'b0);        // id beyond grid
    table_request(KIND_EXPAND, 0, 0, 1'b0, 10, 0, 1'b0, 1'b0, 1'b0);
    table_request(KIND_EXPAND, 0, 0, 1'b0, 64, 0, 1'b0, 1'b0, 1'b0);        // source beyond grid
    table_config(CFG_COLUMNS, 127);
    table_config(CFG_ROWS, 0);
    table_request(KIND_EXPAND, 0, 0, 1'b0, 1, 0, 1'b0, 1'b0, 1'b0);
    table_request(KIND_QUERY, 0, 0, 1'b0, 4095, 4095, 1'b1, 1'b1, 1'b0);
    table_request(KIND_WRITE, 63, 63, 1'b0, 0, 0, 1'b1, 1'b0, 1'b0);        // outside grid

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        wait_drain();
        write_config(row.cfg_sel, row.cfg_val);
      end else begin
        typed_res           = '0;
        typed_res.reachable = row.t_reach;
        typed_res.step_cost = row.t_cost;
        typed_res.last      = 1'b1;
        issue_request(row.req, row.typed, typed_res);
        if ($urandom_range(0, 2) == 0) idle_cycles(int'($urandom_range(1, 4)));
      end
    end

    // random part: one size setting per phase, written while the block is idle
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin cols_val = 64;  rows_val = 64;  end
        1: begin cols_val = 1;   rows_val = 1;   end
        2: begin cols_val = 2;   rows_val = 2;   end
        3: begin cols_val = 5;   rows_val = 3;   end
        4: begin cols_val = 127; rows_val = 1;   end
        5: begin cols_val = 1;   rows_val = 100; end
        6: begin cols_val = 3;   rows_val = 7;   end
        default: begin
          cols_val = int'($urandom_range(0, 127));
          rows_val = int'($urandom_range(0, 127));
        end
      endcase
      wait_drain();
      write_config(CFG_COLUMNS, COORD_W'(cols_val));
      write_config(CFG_ROWS, COORD_W'(rows_val));
      no_gaps    = (phase == 2);  // one phase back to back
      burst_left = 0;
      count      = 0;
      while (count < ITEMS_PER_PHASE) begin
        if (!no_gaps && burst_left == 0) begin
          idle_cycles(int'($urandom_range(1, 15)));
          burst_left = int'($urandom_range(1, 10));
        end
        if (burst_left > 0) burst_left--;
        // now and then hold the sender until every result is back
        if ($urandom_range(0, 39) == 0) wait_drain();
        random_request(req);
        issue_request(req, 1'b0, '0);
        if (req.kind != KIND_UNUSED) count++;
      end
    end

    wait_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
